/* design/assert_macros.svh */
// Assertion helpers used by the core design file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define ASSERT_IMPLY(name, ck, rs, ante, cons) \
  name: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define ASSERT_NEXT(name, ck, rs, ante, cons) \
  name: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* design/grm_pkg.sv */
`timescale 1ns / 1ps
package grm_pkg;
  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_RUN   = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;
  localparam int KIND_W = 3;
endpackage

/* design/grm_ram.sv */
`timescale 1ns / 1ps
// Simple dual-port memory: one write port, one read port with registered data.
module grm_ram #(
  parameter int AW = 12,
  parameter int DW = 4
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);
  logic [DW-1:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

/* design/grid_rectangle_merge_core.sv */
`timescale 1ns / 1ps
// Greedy rectangle merging over a tile grid held in on-chip memory.
// Commands enter through start/opcode and are taken when busy is low. Every
// command gives one result transfer: done is high for exactly one cycle with
// the rect_* fields, and the receiver cannot hold it off.
// A cell write's result follows in the next cycle.
// A cell read reads the claim memory, then the extent of the owning
// rectangle, and then registers the result.
// A merge run first sweeps the claim memory, one entry a cycle over the full
// address space of 2^(clog2(W)+clog2(H)) entries, then visits the cells in
// column order: each scanned cell is read, evaluated and advanced past, each
// cell probed while growing down or right is read and evaluated, each strip
// attempt is checked, each claimed strip is written cell by cell and each
// rectangle's extent is stored.
// After reset the block clears the presence and claim memories with the same
// sweep and holds busy high during it; configuration writes are still taken.
// The unmergeable kind mask is written through cfg_wr_en and cfg_wr_data and
// must only change while the block is idle.
module grid_rectangle_merge_core #(
  parameter int GRID_WIDTH  = 64,
  parameter int GRID_HEIGHT = 64
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  logic [1:0] opcode,
  input  logic [5:0] cell_x,
  input  logic [5:0] cell_y,
  input  logic       cell_present,
  input  logic [2:0] cell_kind,
  input  logic       cfg_wr_en,
  input  logic [7:0] cfg_wr_data,
  output logic       done,
  output logic       rect_present,
  output logic [5:0] rect_x0,
  output logic [5:0] rect_y0,
  output logic [6:0] rect_width,
  output logic [6:0] rect_height,
  output logic [2:0] rect_kind
);
  localparam int XW = $clog2(GRID_WIDTH);
  localparam int YW = $clog2(GRID_HEIGHT);
  localparam int AW = XW + YW;
  localparam int KW = grm_pkg::KIND_W;
  localparam int CW = 1 + KW;        // presence and kind
  localparam int LW = 1 + AW;        // claimed flag and owner corner
  localparam int EW = XW + YW + KW;  // width-1, height-1 and kind

  localparam logic [3:0] S_CLR    = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_RUNCLR = 4'd2;
  localparam logic [3:0] S_SRD    = 4'd3;
  localparam logic [3:0] S_SEV    = 4'd4;
  localparam logic [3:0] S_DRD    = 4'd5;
  localparam logic [3:0] S_DEV    = 4'd6;
  localparam logic [3:0] S_RSTART = 4'd7;
  localparam logic [3:0] S_RRD    = 4'd8;
  localparam logic [3:0] S_REV    = 4'd9;
  localparam logic [3:0] S_RCL    = 4'd10;
  localparam logic [3:0] S_FIN    = 4'd11;
  localparam logic [3:0] S_ADV    = 4'd12;
  localparam logic [3:0] S_RD1    = 4'd13;
  localparam logic [3:0] S_RD2    = 4'd14;

  logic [3:0]    state;
  logic [7:0]    unmergeable_kinds;
  logic [AW-1:0] sweep;
  logic [XW-1:0] sx, px, w;
  logic [YW-1:0] sy, py, h, j;
  logic [KW-1:0] k;
  logic          rd_inside;
  logic          hit;
  logic [XW-1:0] ox;
  logic [YW-1:0] oy;

  logic [XW-1:0] in_x;
  logic [YW-1:0] in_y;
  logic          in_inside;
  logic          accept;
  logic [XW:0]   next_col;

  logic          cell_we, claim_we, ext_we;
  logic [AW-1:0] cell_waddr, claim_waddr, cell_raddr, ext_raddr;
  logic [CW-1:0] cell_wdata, cell_rdata;
  logic [LW-1:0] claim_wdata, claim_rdata;
  logic [EW-1:0] ext_wdata, ext_rdata;
  logic          can_take;

  assign in_x      = XW'(cell_x);
  assign in_y      = YW'(cell_y);
  assign in_inside = (32'(cell_x) < GRID_WIDTH) && (32'(cell_y) < GRID_HEIGHT);
  assign busy      = (state != S_IDLE);
  assign accept    = start && !busy;
  assign next_col  = {1'b0, sx} + {1'b0, w} + {{XW{1'b0}}, 1'b1};

  // A cell qualifies when present, not yet claimed in this run and of the
  // rectangle's kind.
  assign can_take = cell_rdata[CW-1] && !claim_rdata[LW-1] && (cell_rdata[KW-1:0] == k);

  // Cell and claim memories share one read address; while idle it follows
  // the command so a read can start at the accepting edge.
  assign cell_raddr = (state == S_IDLE) ? {in_x, in_y} : {px, py};
  assign ext_raddr  = claim_rdata[AW-1:0];

  always_comb begin
    cell_we     = 1'b0;
    cell_waddr  = {in_x, in_y};
    cell_wdata  = {cell_present, cell_kind};
    claim_we    = 1'b0;
    claim_waddr = {px, py};
    claim_wdata = {1'b1, sx, sy};
    ext_we      = 1'b0;
    ext_wdata   = {w, h, k};
    unique case (state)
      S_CLR: begin
        cell_we     = 1'b1;
        cell_waddr  = sweep;
        cell_wdata  = '0;
        claim_we    = 1'b1;
        claim_waddr = sweep;
        claim_wdata = '0;
      end
      S_IDLE: begin
        cell_we = accept && (opcode == grm_pkg::OP_WRITE) && in_inside;
      end
      S_RUNCLR: begin
        claim_we    = 1'b1;
        claim_waddr = sweep;
        claim_wdata = '0;
      end
      S_SEV: begin
        claim_we = cell_rdata[CW-1] && !claim_rdata[LW-1];
      end
      S_DEV: begin
        claim_we = can_take;
      end
      S_RCL: begin
        claim_we = 1'b1;
      end
      S_FIN: begin
        ext_we = 1'b1;
      end
      default: begin
      end
    endcase
  end

  grm_ram #(.AW(AW), .DW(CW)) u_cell_ram (
    .clk(clk), .we(cell_we), .waddr(cell_waddr), .wdata(cell_wdata),
    .raddr(cell_raddr), .rdata(cell_rdata)
  );

  grm_ram #(.AW(AW), .DW(LW)) u_claim_ram (
    .clk(clk), .we(claim_we), .waddr(claim_waddr), .wdata(claim_wdata),
    .raddr(cell_raddr), .rdata(claim_rdata)
  );

  grm_ram #(.AW(AW), .DW(EW)) u_ext_ram (
    .clk(clk), .we(ext_we), .waddr({sx, sy}), .wdata(ext_wdata),
    .raddr(ext_raddr), .rdata(ext_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      unmergeable_kinds <= '0;
    end else if (cfg_wr_en) begin
      unmergeable_kinds <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR;
      sweep <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_CLR: begin
          sweep <= sweep + 1'b1;
          if (sweep == '1) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            rect_present <= 1'b0;
            rect_x0      <= '0;
            rect_y0      <= '0;
            rect_width   <= '0;
            rect_height  <= '0;
            rect_kind    <= '0;
            rd_inside    <= in_inside;
            if (opcode == grm_pkg::OP_RUN) begin
              sweep <= '0;
              state <= S_RUNCLR;
            end else if (opcode == grm_pkg::OP_READ) begin
              state <= S_RD1;
            end else begin
              done <= 1'b1;
            end
          end
        end
        S_RUNCLR: begin
          sweep <= sweep + 1'b1;
          if (sweep == '1) begin
            sx    <= '0;
            sy    <= '0;
            px    <= '0;
            py    <= '0;
            state <= S_SRD;
          end
        end
        S_SRD: begin
          state <= S_SEV;
        end
        S_SEV: begin
          k <= cell_rdata[KW-1:0];
          h <= '0;
          w <= '0;
          if (cell_rdata[CW-1] && !claim_rdata[LW-1]) begin
            if (unmergeable_kinds[cell_rdata[KW-1:0]]) begin
              state <= S_FIN;
            end else if (32'(sy) < GRID_HEIGHT - 1) begin
              py    <= sy + 1'b1;
              state <= S_DRD;
            end else begin
              state <= S_RSTART;
            end
          end else begin
            state <= S_ADV;
          end
        end
        S_DRD: begin
          state <= S_DEV;
        end
        S_DEV: begin
          if (can_take) begin
            h <= h + 1'b1;
            if (32'(py) < GRID_HEIGHT - 1) begin
              py    <= py + 1'b1;
              state <= S_DRD;
            end else begin
              state <= S_RSTART;
            end
          end else begin
            state <= S_RSTART;
          end
        end
        S_RSTART: begin
          if (32'(next_col) < GRID_WIDTH) begin
            px    <= next_col[XW-1:0];
            py    <= sy;
            j     <= '0;
            state <= S_RRD;
          end else begin
            state <= S_FIN;
          end
        end
        S_RRD: begin
          state <= S_REV;
        end
        S_REV: begin
          if (!can_take) begin
            state <= S_FIN;
          end else if (j == h) begin
            py    <= sy;
            j     <= '0;
            state <= S_RCL;
          end else begin
            j     <= j + 1'b1;
            py    <= py + 1'b1;
            state <= S_RRD;
          end
        end
        S_RCL: begin
          if (j == h) begin
            w     <= w + 1'b1;
            state <= S_RSTART;
          end else begin
            j  <= j + 1'b1;
            py <= py + 1'b1;
          end
        end
        S_FIN: begin
          state <= S_ADV;
        end
        S_ADV: begin
          if (32'(sy) == GRID_HEIGHT - 1) begin
            if (32'(sx) == GRID_WIDTH - 1) begin
              done  <= 1'b1;
              state <= S_IDLE;
            end else begin
              sx    <= sx + 1'b1;
              sy    <= '0;
              px    <= sx + 1'b1;
              py    <= '0;
              state <= S_SRD;
            end
          end else begin
            sy    <= sy + 1'b1;
            px    <= sx;
            py    <= sy + 1'b1;
            state <= S_SRD;
          end
        end
        S_RD1: begin
          hit   <= rd_inside && claim_rdata[LW-1];
          ox    <= claim_rdata[AW-1:YW];
          oy    <= claim_rdata[YW-1:0];
          state <= S_RD2;
        end
        S_RD2: begin
          done <= 1'b1;
          if (hit) begin
            rect_present <= 1'b1;
            rect_x0      <= 6'(ox);
            rect_y0      <= 6'(oy);
            rect_width   <= 7'({1'b0, ext_rdata[EW-1:YW+KW]} + 1'b1);
            rect_height  <= 7'({1'b0, ext_rdata[YW+KW-1:KW]} + 1'b1);
            rect_kind    <= ext_rdata[KW-1:0];
          end
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`include "assert_macros.svh"

  `ASSERT_NEXT(a_write_result, clk, rst, start && !busy && opcode != grm_pkg::OP_RUN && opcode != grm_pkg::OP_READ, done && !rect_present)
  `ASSERT_NEXT(a_run_holds_busy, clk, rst, start && !busy && opcode == grm_pkg::OP_RUN, busy && !done)
  `ASSERT_IMPLY(a_done_when_idle, clk, rst, done, !busy)
  `ASSERT_IMPLY(a_miss_is_zero, clk, rst, done && !rect_present, rect_width == 0 && rect_height == 0)

endmodule
